### rtl/ssd_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ssd_pkg
// Shared types and constants of the snapshot set difference block.
// ============================================================================
package ssd_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CFG_W    = 5;
  localparam int OCNT_W   = 5;

  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_END    = 2'd1,
    OP_FAIL   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_APPEARED = 2'd0,
    KIND_VANISHED = 2'd1,
    KIND_SUMMARY  = 2'd2,
    KIND_FAILED   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [63:0] key;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic commit;
    logic rot;
  } cell_ctl_t;

endpackage

### rtl/ssd_if.sv
`timescale 1ns / 1ps
// ============================================================================
// ssd channel interfaces
// Input, result and configuration channels with valid/ready handshakes.
// ============================================================================
interface ssd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] address;
  logic [31:0] handle;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  modport source (output valid, operation, address, handle, pos_x, pos_y, pos_z,
                  input ready);
  modport sink (input valid, operation, address, handle, pos_x, pos_y, pos_z,
                output ready);
endinterface

interface ssd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] obj_address;
  logic [31:0] obj_handle;
  logic [31:0] obj_pos_x;
  logic [31:0] obj_pos_y;
  logic [31:0] obj_pos_z;
  logic [4:0]  object_count;
  logic        was_truncated;
  logic        compared;
  logic [31:0] sample_number;
  logic        last;
  modport source (output valid, kind, obj_address, obj_handle, obj_pos_x, obj_pos_y,
                  obj_pos_z, object_count, was_truncated, compared, sample_number,
                  last, input ready);
  modport sink (input valid, kind, obj_address, obj_handle, obj_pos_x, obj_pos_y,
                obj_pos_z, object_count, was_truncated, compared, sample_number,
                last, output ready);
endinterface

interface ssd_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### rtl/ssd_cell.sv
`timescale 1ns / 1ps
// ============================================================================
// ssd_cell
// One slot of the sorting chain: scratch, current and previous entries.
// ============================================================================
module ssd_cell (
  input  logic              clk,
  input  ssd_pkg::cell_ctl_t ctl,
  input  ssd_pkg::entry_t   ins_rec,
  input  ssd_pkg::entry_t   left_scr,
  input  logic              left_gt,
  input  logic              scr_v,
  input  logic              cur_v,
  input  ssd_pkg::entry_t   left_prev,
  input  logic              left_pv,
  input  logic              left_pf,
  output ssd_pkg::entry_t   scr,
  output logic              gt,
  output ssd_pkg::entry_t   cur,
  output logic              cur_found,
  output ssd_pkg::entry_t   prev,
  output logic              pv,
  output logic              pf_out
);
  import ssd_pkg::*;

  entry_t scr_r, cur_r, prev_r;
  logic   cf_r, pv_r, pf_r;
  logic   match;

  // An empty slot counts as greater, so a new record lands after all equal keys.
  assign gt    = !scr_v || (scr_r.key > ins_rec.key);
  assign match = pv_r && cur_v && (prev_r.key == cur_r.key);

  always_ff @(posedge clk) begin
    if (ctl.ins && gt) begin
      scr_r <= left_gt ? left_scr : ins_rec;
    end
    if (ctl.commit) begin
      prev_r <= cur_r;
      pv_r   <= cur_v;
      pf_r   <= 1'b0;
      cur_r  <= scr_r;
      cf_r   <= 1'b0;
    end else if (ctl.rot) begin
      prev_r <= left_prev;
      pv_r   <= left_pv;
      pf_r   <= left_pf;
      cf_r   <= cf_r | match;
    end
  end

  assign scr       = scr_r;
  assign cur       = cur_r;
  assign cur_found = cf_r;
  assign prev      = prev_r;
  assign pv        = pv_r;
  assign pf_out    = pf_r | match;

endmodule

### rtl/snapshot_set_difference.sv
`timescale 1ns / 1ps
// ============================================================================
// snapshot_set_difference
// Collects object records, sorts them and reports appeared and vanished ones.
// ============================================================================
// Records are inserted in key order into a chain of CAPACITY cells as they
// arrive, one beat per cycle while ready is high. An end of sample commits the
// chain to current; when a difference is made, the previous entries then
// circulate once round the chain to mark matches, and a walk over the cells
// gives the appeared and vanished results, which stall on the output, before
// the summary. A sample without difference goes straight to its summary.
// Failure and clear items are handled in the idle state. New items are taken
// only when the block is idle and its output register is free.
module snapshot_set_difference (
  input logic clk,
  input logic rst_n,
  ssd_in_if.sink    in_ch,
  ssd_out_if.source out_ch,
  ssd_cfg_if.sink   cfg_ch
);
  import ssd_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MATCH, S_EMIT_A, S_EMIT_P, S_SUMM} state_t;

  state_t            state_r;
  logic [CFG_W-1:0]  cap_r;
  logic [CNT_W-1:0]  fill_r, cur_cnt_r;
  logic              primed_r, trunc_r, cmp_r;
  logic [31:0]       counter_r;
  logic [IDX_W-1:0]  ptr_r;

  logic              out_valid_r;
  kind_t             kind_r;
  entry_t            obj_r;
  logic [OCNT_W-1:0] ocnt_r;
  logic              otrunc_r, ocmp_r, olast_r;
  logic [31:0]       onum_r;

  logic [CFG_W-1:0]  eff_cap;
  logic              can_load, accept, room, trunc_nxt;
  cell_ctl_t         ctl;
  entry_t            ins_rec;

  entry_t            scr_q [CAPACITY];
  entry_t            cur_q [CAPACITY];
  entry_t            prev_q [CAPACITY];
  logic [CAPACITY-1:0] gt_q, cf_q, pv_q, pf_q;

  assign eff_cap = (cap_r == '0) ? CFG_W'(1) :
                   (cap_r > CFG_W'(CAPACITY)) ? CFG_W'(CAPACITY) : cap_r;
  assign can_load = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && can_load;
  assign cfg_ch.ready = 1'b1;
  assign accept = in_ch.valid && in_ch.ready;
  assign room = (CFG_W'(fill_r) < eff_cap) && (fill_r < CNT_W'(CAPACITY));
  assign trunc_nxt = CFG_W'(fill_r) >= eff_cap;

  assign ins_rec.key   = {in_ch.address, in_ch.handle};
  assign ins_rec.pos_x = in_ch.pos_x;
  assign ins_rec.pos_y = in_ch.pos_y;
  assign ins_rec.pos_z = in_ch.pos_z;

  assign ctl.ins    = accept && (op_t'(in_ch.operation) == OP_RECORD) && room;
  assign ctl.commit = accept && (op_t'(in_ch.operation) == OP_END);
  assign ctl.rot    = (state_r == S_MATCH);

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      localparam int LI = (gi == 0) ? CAPACITY - 1 : gi - 1;
      ssd_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .ins_rec   (ins_rec),
        .left_scr  (scr_q[LI]),
        .left_gt   ((gi == 0) ? 1'b0 : gt_q[LI]),
        .scr_v     (fill_r > CNT_W'(gi)),
        .cur_v     (cur_cnt_r > CNT_W'(gi)),
        .left_prev (prev_q[LI]),
        .left_pv   (pv_q[LI]),
        .left_pf   (pf_q[LI]),
        .scr       (scr_q[gi]),
        .gt        (gt_q[gi]),
        .cur       (cur_q[gi]),
        .cur_found (cf_q[gi]),
        .prev      (prev_q[gi]),
        .pv        (pv_q[gi]),
        .pf_out    (pf_q[gi])
      );
    end
  endgenerate

  logic want_a, want_p, ptr_end;
  assign want_a  = (CNT_W'(ptr_r) < cur_cnt_r) && !cf_q[ptr_r];
  assign want_p  = pv_q[ptr_r] && !pf_q[ptr_r];
  assign ptr_end = (ptr_r == IDX_W'(CAPACITY - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CFG_W'(CAPACITY);
      fill_r      <= '0;
      cur_cnt_r   <= '0;
      primed_r    <= 1'b0;
      trunc_r     <= 1'b0;
      cmp_r       <= 1'b0;
      counter_r   <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        cap_r <= cfg_ch.data;
      end
      if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            unique case (op_t'(in_ch.operation))
              OP_RECORD: begin
                if (room) fill_r <= fill_r + 1'b1;
              end
              OP_END: begin
                cur_cnt_r  <= fill_r;
                fill_r     <= '0;
                trunc_r    <= trunc_nxt;
                primed_r   <= 1'b1;
                counter_r  <= counter_r + 32'd1;
                cmp_r      <= primed_r && !trunc_nxt;
                ptr_r      <= '0;
                state_r    <= (primed_r && !trunc_nxt) ? S_MATCH : S_SUMM;
              end
              OP_FAIL: begin
                fill_r      <= '0;
                out_valid_r <= 1'b1;
                kind_r      <= KIND_FAILED;
                obj_r       <= '0;
                ocnt_r      <= '0;
                otrunc_r    <= 1'b0;
                ocmp_r      <= 1'b0;
                onum_r      <= '0;
                olast_r     <= 1'b1;
              end
              default: begin
                fill_r     <= '0;
                cur_cnt_r  <= '0;
                primed_r   <= 1'b0;
                trunc_r    <= 1'b0;
                counter_r  <= '0;
              end
            endcase
          end
        end
        S_MATCH: begin
          ptr_r <= ptr_r + 1'b1;
          if (ptr_end) begin
            ptr_r   <= '0;
            state_r <= S_EMIT_A;
          end
        end
        S_EMIT_A, S_EMIT_P: begin
          if (((state_r == S_EMIT_A) ? !want_a : !want_p) || can_load) begin
            if ((state_r == S_EMIT_A) ? want_a : want_p) begin
              out_valid_r <= 1'b1;
              kind_r      <= (state_r == S_EMIT_A) ? KIND_APPEARED : KIND_VANISHED;
              obj_r       <= (state_r == S_EMIT_A) ? cur_q[ptr_r] : prev_q[ptr_r];
              ocnt_r      <= '0;
              otrunc_r    <= 1'b0;
              ocmp_r      <= 1'b0;
              onum_r      <= '0;
              olast_r     <= 1'b0;
            end
            ptr_r <= ptr_r + 1'b1;
            if (ptr_end) begin
              ptr_r   <= '0;
              state_r <= (state_r == S_EMIT_A) ? S_EMIT_P : S_SUMM;
            end
          end
        end
        S_SUMM: begin
          if (can_load) begin
            out_valid_r <= 1'b1;
            kind_r      <= KIND_SUMMARY;
            obj_r       <= '0;
            ocnt_r      <= OCNT_W'(cur_cnt_r);
            otrunc_r    <= trunc_r;
            ocmp_r      <= cmp_r;
            onum_r      <= counter_r;
            olast_r     <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = kind_r;
  assign out_ch.obj_address   = obj_r.key[63:32];
  assign out_ch.obj_handle    = obj_r.key[31:0];
  assign out_ch.obj_pos_x     = obj_r.pos_x;
  assign out_ch.obj_pos_y     = obj_r.pos_y;
  assign out_ch.obj_pos_z     = obj_r.pos_z;
  assign out_ch.object_count  = ocnt_r;
  assign out_ch.was_truncated = otrunc_r;
  assign out_ch.compared      = ocmp_r;
  assign out_ch.sample_number = onum_r;
  assign out_ch.last          = olast_r;

  // The chain can never hold more records than it has cells.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(CAPACITY) && cur_cnt_r <= CNT_W'(CAPACITY))
    else $error("record count exceeds the chain length");

  // A summary beat always returns the block to idle.
  a_summ_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUMM && can_load) |=> (state_r == S_IDLE && out_valid_r && olast_r))
    else $error("summary did not finish the item");

  // Matching only runs for a comparable sample.
  a_match_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MATCH) |-> (cmp_r && primed_r && !trunc_r))
    else $error("difference made on a sample that is not comparable");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Drives record, end-of-sample, failure and clear beats into the snapshot
// differencer and checks every result against a behavioural predictor.
// ============================================================================
module tb_top;
  import ssd_pkg::*;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] address;
    logic [31:0] handle;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
  } beat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] obj_address;
    logic [31:0] obj_handle;
    logic [31:0] obj_pos_x;
    logic [31:0] obj_pos_y;
    logic [31:0] obj_pos_z;
    logic [4:0]  object_count;
    logic        was_truncated;
    logic        compared;
    logic [31:0] sample_number;
    logic        last;
  } change_t;

  typedef struct packed {
    logic [63:0] key;
    logic [95:0] pos;
  } rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ssd_in_if  in_ch ();
  ssd_out_if out_ch ();
  ssd_cfg_if cfg_ch ();

  snapshot_set_difference dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #6 clk = ~clk;

  beat_t   pending_beats[$];
  change_t expected_changes[$];
  int      errors = 0;
  bit      cfg_req = 1'b0;
  logic [4:0] cfg_value;
  bit      cfg_done = 1'b0;

  // Predictor state.
  rec_t       scratch_recs[$];
  rec_t       current_recs[$];
  rec_t       previous_recs[$];
  bit         primed;
  logic [31:0] sample_count;
  logic [4:0] capacity_reg = 5'd16;

  function automatic void add_beat(beat_t b);
    pending_beats.insert(pending_beats.size(), b);
  endfunction

  function automatic void add_change(change_t c);
    expected_changes.insert(expected_changes.size(), c);
  endfunction

  function automatic void add_scratch(rec_t r);
    scratch_recs.insert(scratch_recs.size(), r);
  endfunction

  function automatic int eff_capacity();
    int c;
    c = capacity_reg;
    if (c < 1) c = 1;
    if (c > CAPACITY) c = CAPACITY;
    return c;
  endfunction

  function automatic bit holds_key(ref rec_t recs[$], input logic [63:0] key);
    foreach (recs[i]) if (recs[i].key == key) return 1'b1;
    return 1'b0;
  endfunction

  function automatic change_t obj_change(kind_t k, rec_t r);
    change_t c;
    c = '0;
    c.kind = k;
    {c.obj_address, c.obj_handle} = r.key;
    {c.obj_pos_x, c.obj_pos_y, c.obj_pos_z} = r.pos;
    return c;
  endfunction

  task automatic predict_changes(beat_t b);
    change_t c;
    rec_t    r;
    rec_t    sorted[$];
    int      j;
    bit      cmp;
    bit      trunc;
    c = '0;
    case (op_t'(b.operation))
      OP_RECORD: begin
        if (scratch_recs.size() < eff_capacity()) begin
          r.key = {b.address, b.handle};
          r.pos = {b.pos_x, b.pos_y, b.pos_z};
          add_scratch(r);
        end
      end
      OP_FAIL: begin
        scratch_recs.delete();
        c.kind = KIND_FAILED;
        c.last = 1'b1;
        add_change(c);
      end
      OP_CLEAR: begin
        scratch_recs.delete();
        current_recs.delete();
        previous_recs.delete();
        primed = 1'b0;
        sample_count = '0;
      end
      default: begin
        // Stable insertion sort keeps arrival order among equal keys.
        foreach (scratch_recs[i]) begin
          j = sorted.size();
          while (j > 0 && sorted[j-1].key > scratch_recs[i].key) j--;
          sorted.insert(j, scratch_recs[i]);
        end
        scratch_recs.delete();
        previous_recs = current_recs;
        current_recs = sorted;
        trunc = current_recs.size() >= eff_capacity();
        cmp = primed && !trunc;
        primed = 1'b1;
        sample_count = sample_count + 32'd1;
        if (cmp) begin
          foreach (current_recs[i])
            if (!holds_key(previous_recs, current_recs[i].key))
              add_change(obj_change(KIND_APPEARED, current_recs[i]));
          foreach (previous_recs[i])
            if (!holds_key(current_recs, previous_recs[i].key))
              add_change(obj_change(KIND_VANISHED, previous_recs[i]));
        end
        c.kind = KIND_SUMMARY;
        c.object_count = 5'(current_recs.size());
        c.was_truncated = trunc;
        c.compared = cmp;
        c.sample_number = sample_count;
        c.last = 1'b1;
        add_change(c);
      end
    endcase
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Input driver.
  int in_gap = 0;
  bit in_hold = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_changes(beat_t'({in_ch.operation, in_ch.address, in_ch.handle,
                                 in_ch.pos_x, in_ch.pos_y, in_ch.pos_z}));
        in_gap = in_hold ? 0 : gap_len();
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (in_gap > 0 || pending_beats.size() == 0) begin
          if (in_gap > 0) in_gap--;
          in_ch.valid <= 1'b0;
        end else begin
          {in_ch.operation, in_ch.address, in_ch.handle, in_ch.pos_x, in_ch.pos_y,
           in_ch.pos_z} <= pending_beats.pop_front();
          in_ch.valid <= 1'b1;
        end
      end
    end
  end

  // Configuration driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_ch.valid <= 1'b0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      capacity_reg = cfg_ch.data;
      cfg_ch.valid <= 1'b0;
      cfg_req = 1'b0;
      cfg_done = 1'b1;
    end else if (cfg_req && !cfg_ch.valid) begin
      cfg_ch.data <= cfg_value;
      cfg_ch.valid <= 1'b1;
    end
  end

  // Result monitor with random back-pressure.
  int out_gap = 0;
  change_t seen;
  change_t want;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen = {out_ch.kind, out_ch.obj_address, out_ch.obj_handle, out_ch.obj_pos_x,
                out_ch.obj_pos_y, out_ch.obj_pos_z, out_ch.object_count,
                out_ch.was_truncated, out_ch.compared, out_ch.sample_number,
                out_ch.last};
        if (expected_changes.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %h", $time, seen);
        end else begin
          want = expected_changes.pop_front();
          if (seen !== want) begin
            errors++;
            $display("%0t: result mismatch, expected %h, actual %h", $time, want, seen);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_gap = gap_len();
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic beat_t make_record(logic [31:0] a, logic [31:0] h);
    beat_t b;
    b.operation = OP_RECORD;
    b.address = a;
    b.handle = h;
    b.pos_x = $urandom();
    b.pos_y = $urandom();
    b.pos_z = $urandom();
    return b;
  endfunction

  function automatic beat_t make_op(op_t op);
    beat_t b;
    b = make_record($urandom(), $urandom());
    b.operation = op;
    return b;
  endfunction

  task automatic settle();
    in_hold = 1'b1;
    while (pending_beats.size() != 0 || in_ch.valid || expected_changes.size() != 0)
      @(posedge clk);
    repeat (4 * CAPACITY + 10) @(posedge clk);
    in_hold = 1'b0;
  endtask

  task automatic write_capacity(logic [4:0] v);
    cfg_value = v;
    cfg_done = 1'b0;
    cfg_req = 1'b1;
    while (!cfg_done) @(posedge clk);
  endtask

  // Key pool kept small so that samples overlap and duplicates occur.
  logic [63:0] key_pool[8];

  task automatic random_sample(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 7);
      if ($urandom_range(0, 5) == 0) k = -1;
      if (k < 0) add_beat(make_record($urandom(), $urandom()));
      else add_beat(make_record(key_pool[k][63:32], key_pool[k][31:0]));
    end
    add_beat(make_op($urandom_range(0, 9) == 0 ? OP_FAIL : OP_END));
  endtask

  logic [4:0] caps[6] = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd5, 5'd12};

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = OP_RECORD;
    {in_ch.address, in_ch.handle, in_ch.pos_x, in_ch.pos_y, in_ch.pos_z} = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    primed = 1'b0;
    sample_count = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, duplicates, failure, clear, truncation.
    add_beat(make_record(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    add_beat(make_record(32'h0, 32'h0));
    add_beat(make_record(32'h5, 32'h1));
    add_beat(make_op(OP_END));
    add_beat(make_record(32'h5, 32'h1));
    add_beat(make_record(32'h5, 32'h1));
    add_beat(make_record(32'h0, 32'hFFFF_FFFF));
    add_beat(make_op(OP_END));
    add_beat(make_record(32'h9, 32'h9));
    add_beat(make_op(OP_FAIL));
    add_beat(make_op(OP_END));
    add_beat(make_op(OP_END));
    add_beat(make_op(OP_CLEAR));
    add_beat(make_record(32'h1, 32'h2));
    add_beat(make_op(OP_END));
    add_beat(make_op(OP_CLEAR));
    settle();
    write_capacity(5'd2);
    add_beat(make_op(OP_END));
    for (int i = 0; i < 3; i++) add_beat(make_record(32'(i), 32'(i)));
    add_beat(make_op(OP_END));
    settle();

    // Random phases across capacity settings, extremes included.
    foreach (caps[c]) begin
      write_capacity(caps[c]);
      foreach (key_pool[i]) key_pool[i] = {$urandom(), $urandom()};
      for (int s = 0; s < 7; s++) begin
        if ($urandom_range(0, 19) == 0) add_beat(make_op(OP_CLEAR));
        random_sample($urandom_range(0, 99) < 85 ? $urandom_range(0, 6)
                                                  : $urandom_range(10, 20));
      end
      settle();
    end

    if (errors == 0) $display("** snapshot_set_difference: PASSED **");
    else $display("** snapshot_set_difference: FAILED **");
    $finish;
  end

  initial begin
    #20ms;
    $display("** snapshot_set_difference: FAILED **");
    $finish;
  end

endmodule
